>>> rtl/core/xcpr_pkg.sv
// ----------------------------------------------------------------------------
// xcpr_pkg: shared types and constants
// Word kinds, protocol byte codes and the command record passed from the
// front end to the back end of the XMODEM-CRC receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package xcpr_pkg;

  // op codes on the input tuser
  localparam logic [1:0] OP_START    = 2'd0;
  localparam logic [1:0] OP_BYTE     = 2'd1;
  localparam logic [1:0] OP_LINE_ERR = 2'd2;

  // classified word kinds
  localparam logic [1:0] KIND_START    = 2'd0;
  localparam logic [1:0] KIND_BYTE     = 2'd1;
  localparam logic [1:0] KIND_LINE_ERR = 2'd2;
  localparam logic [1:0] KIND_NONE     = 2'd3;

  localparam logic [7:0] BYTE_SOH = 8'h01;
  localparam logic [7:0] BYTE_EOT = 8'h04;
  localparam logic [7:0] BYTE_ACK = 8'h06;
  localparam logic [7:0] BYTE_NAK = 8'h15;
  localparam logic [7:0] BYTE_CAN = 8'h18;
  localparam logic [7:0] BYTE_EOF = 8'h1A;
  localparam logic [7:0] BYTE_REQ = 8'h43;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [1:0] VERDICT_NONE   = 2'd0;
  localparam logic [1:0] VERDICT_COMMIT = 2'd1;
  localparam logic [1:0] VERDICT_DROP   = 2'd2;

  localparam logic [1:0] SEND_RUNNING   = 2'd0;
  localparam logic [1:0] SEND_COMPLETE  = 2'd1;
  localparam logic [1:0] SEND_CANCELLED = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
    logic       is_eof;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/xmodem_crc_packet_receiver_unit.sv
// ----------------------------------------------------------------------------
// xmodem_crc_packet_receiver_unit: XMODEM-CRC receiver, top level
// A word waits in the queue; its result is then registered in the output word.
// Throughput: one word per cycle unless out_tready stalls the output; the
// CRC-16 byte update and the header compares in the engine are combinational.
// A two-entry queue sits between classifier and engine, so either side may stall.
// Reset (rst_n low, synchronous): session stopped, packet 1 expected, queue empty.
// ----------------------------------------------------------------------------
`default_nettype none

module xmodem_crc_packet_receiver_unit #(
  parameter int PAYLOAD_BYTES = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic [1:0]  in_tuser,   // [1:0] op
  input  wire logic        in_tlast,   // chunk_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] payload_valid, [8:1] payload_byte, [9] reply_valid, [17:10] reply_byte,
  // [19:18] packet_verdict, [21:20] session_end, [23:22] zero
  output logic [23:0]      out_tdata
);
  import xcpr_pkg::*;

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic q_valid;
  logic q_pop;

  xcpr_front u_front (
    .op_i   (in_tuser),
    .data_i (in_tdata),
    .last_i (in_tlast),
    .cmd_o  (front_cmd)
  );

  xcpr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (in_tvalid),
    .push_cmd_i (front_cmd),
    .ready_o    (in_tready),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (head_cmd)
  );

  xcpr_back #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid_i   (q_valid),
    .q_cmd_i     (head_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_data_o  (out_tdata)
  );

endmodule

`default_nettype wire

>>> rtl/core/xcpr_front.sv
// ----------------------------------------------------------------------------
// xcpr_front: input word classifier
// Decodes the op code into a word kind and tags end-of-file bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module xcpr_front (
  input  wire logic [1:0]     op_i,
  input  wire logic [7:0]     data_i,
  input  wire logic           last_i,
  output xcpr_pkg::cmd_t      cmd_o
);
  import xcpr_pkg::*;

  always_comb begin
    cmd_o = '0;
    case (op_i)
      OP_START:    cmd_o.kind = KIND_START;
      OP_BYTE:     cmd_o.kind = KIND_BYTE;
      OP_LINE_ERR: cmd_o.kind = KIND_LINE_ERR;
      default:     cmd_o.kind = KIND_NONE;
    endcase
    cmd_o.data   = data_i;
    cmd_o.last   = last_i;
    cmd_o.is_eof = (data_i == BYTE_EOF);
  end

endmodule

`default_nettype wire

>>> rtl/core/xcpr_queue.sv
// ----------------------------------------------------------------------------
// xcpr_queue: two-entry command queue
// Decouples the classifier from the protocol engine; full rate while the
// engine pops every word, but a full queue refuses a push even as it pops.
// ----------------------------------------------------------------------------
`default_nettype none

module xcpr_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_i,
  input  wire xcpr_pkg::cmd_t push_cmd_i,
  output logic                ready_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output xcpr_pkg::cmd_t      head_o
);
  import xcpr_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push;

  assign ready_o = (cnt_r != 2'd2);
  assign valid_o = (cnt_r != 2'd0);
  assign head_o  = mem_r[rd_ptr_r];
  assign do_push = push_i && ready_o;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_i ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd_i;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> cnt_r != 2'd0)
    else $error("pop from empty queue");
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !pop_i) |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("push lost");

endmodule

`default_nettype wire

>>> rtl/core/xcpr_back.sv
// ----------------------------------------------------------------------------
// xcpr_back: XMODEM-CRC protocol engine
// Tracks session mode, frame position, header bytes and CRC-16; issues payload
// bytes, replies, verdicts and session ends into a registered output word.
// ----------------------------------------------------------------------------
`default_nettype none

module xcpr_back #(
  parameter int PAYLOAD_BYTES = 128
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid_i,
  input  wire xcpr_pkg::cmd_t q_cmd_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [23:0]         out_data_o
);
  import xcpr_pkg::*;

  localparam int FRAME_BYTES = PAYLOAD_BYTES + 5;
  localparam int PW          = $clog2(FRAME_BYTES + 2);
  localparam logic [PW-1:0] POS_PLD_END = PW'(PAYLOAD_BYTES + 3);
  localparam logic [PW-1:0] POS_CRC_LO  = PW'(PAYLOAD_BYTES + 4);
  localparam logic [PW-1:0] POS_FRAME   = PW'(FRAME_BYTES);
  localparam logic [PW-1:0] POS_SAT     = PW'(FRAME_BYTES + 1);

  localparam logic [1:0] MODE_STOPPED    = 2'd0;
  localparam logic [1:0] MODE_CONNECTING = 2'd1;
  localparam logic [1:0] MODE_READING    = 2'd2;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                             input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  logic [1:0]    mode_r, mode_nxt;
  logic [7:0]    exp_r, exp_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    first_r, first_nxt;
  logic [7:0]    num_r, num_nxt;
  logic [7:0]    comp_r, comp_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic [15:0]   rcrc_r, rcrc_nxt;
  logic          eof_r, eof_nxt;
  logic          out_valid_r;
  logic [23:0]   out_data_r;

  logic          pv, rv, hdr_ok;
  logic [7:0]    pb, rb;
  logic [1:0]    verdict, send;

  assign q_pop_o     = q_valid_i && (!out_valid_r || out_ready_i);
  assign out_valid_o = out_valid_r;
  assign out_data_o  = out_data_r;

  always_comb begin
    mode_nxt  = mode_r;
    exp_nxt   = exp_r;
    pos_nxt   = pos_r;
    first_nxt = first_r;
    num_nxt   = num_r;
    comp_nxt  = comp_r;
    crc_nxt   = crc_r;
    rcrc_nxt  = rcrc_r;
    eof_nxt   = eof_r;
    pv        = 1'b0;
    pb        = 8'h00;
    rv        = 1'b0;
    rb        = 8'h00;
    verdict   = VERDICT_NONE;
    send      = SEND_RUNNING;
    hdr_ok    = 1'b0;
    case (q_cmd_i.kind)
      KIND_START: begin
        mode_nxt = MODE_CONNECTING;
        exp_nxt  = 8'd1;
        pos_nxt  = '0;
      end
      KIND_LINE_ERR: begin
        if (mode_r != MODE_STOPPED) begin
          rv      = 1'b1;
          rb      = (mode_r == MODE_CONNECTING) ? BYTE_REQ : BYTE_NAK;
          verdict = VERDICT_DROP;
        end
        pos_nxt = '0;
      end
      KIND_BYTE: begin
        if (mode_r != MODE_STOPPED) begin
          if (pos_r == PW'(0)) begin
            first_nxt = q_cmd_i.data;
          end else if (pos_r == PW'(1)) begin
            num_nxt = q_cmd_i.data;
          end else if (pos_r == PW'(2)) begin
            comp_nxt = q_cmd_i.data;
          end else if (pos_r < POS_PLD_END) begin
            crc_nxt = crc16_byte(crc_r, q_cmd_i.data);
            if (first_r == BYTE_SOH && !eof_r) begin
              if (q_cmd_i.is_eof) begin
                eof_nxt = 1'b1;
              end else begin
                pv = 1'b1;
                pb = q_cmd_i.data;
              end
            end
          end else if (pos_r == POS_PLD_END) begin
            rcrc_nxt = {q_cmd_i.data, rcrc_r[7:0]};
          end else if (pos_r == POS_CRC_LO) begin
            rcrc_nxt = {rcrc_r[15:8], q_cmd_i.data};
          end
          if (pos_r < POS_SAT) begin
            pos_nxt = pos_r + PW'(1);
          end

          if (q_cmd_i.last) begin
            if (mode_r == MODE_CONNECTING) begin
              mode_nxt = MODE_READING;
            end
            hdr_ok = (num_nxt == exp_r) && (comp_nxt == ~exp_r) && (pos_nxt == POS_FRAME);
            if (first_nxt == BYTE_SOH) begin
              if (!hdr_ok) begin
                verdict = VERDICT_DROP;
              end else if (crc_nxt == rcrc_nxt) begin
                rv      = 1'b1;
                rb      = BYTE_ACK;
                verdict = VERDICT_COMMIT;
                exp_nxt = exp_r + 8'd1;
              end else begin
                rv      = 1'b1;
                rb      = BYTE_NAK;
                verdict = VERDICT_DROP;
              end
            end else if (first_nxt == BYTE_EOT) begin
              send     = SEND_COMPLETE;
              mode_nxt = MODE_STOPPED;
            end else if (first_nxt == BYTE_CAN) begin
              send     = SEND_CANCELLED;
              mode_nxt = MODE_STOPPED;
            end
            pos_nxt = '0;
          end
        end
      end
      default: begin
      end
    endcase
    // any chunk restart wipes the per-chunk record
    if (q_cmd_i.kind != KIND_NONE && pos_nxt == PW'(0)) begin
      first_nxt = 8'h00;
      num_nxt   = 8'h00;
      comp_nxt  = 8'h00;
      crc_nxt   = 16'h0000;
      rcrc_nxt  = 16'h0000;
      eof_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_STOPPED;
      exp_r       <= 8'd1;
      pos_r       <= '0;
      first_r     <= 8'h00;
      num_r       <= 8'h00;
      comp_r      <= 8'h00;
      crc_r       <= 16'h0000;
      rcrc_r      <= 16'h0000;
      eof_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop_o) begin
        mode_r      <= mode_nxt;
        exp_r       <= exp_nxt;
        pos_r       <= pos_nxt;
        first_r     <= first_nxt;
        num_r       <= num_nxt;
        comp_r      <= comp_nxt;
        crc_r       <= crc_nxt;
        rcrc_r      <= rcrc_nxt;
        eof_r       <= eof_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop_o) begin
      out_data_r <= {2'b00, send, verdict, rb, rv, pb, pv};
    end
  end

  a_reply_code: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop_o && rv) |-> (rb == BYTE_ACK || rb == BYTE_NAK || rb == BYTE_REQ))
    else $error("bad reply code");
  a_commit_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop_o && verdict == VERDICT_COMMIT) |-> (rv && rb == BYTE_ACK))
    else $error("commit without ACK");
  a_end_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop_o && send != SEND_RUNNING) |=> mode_r == MODE_STOPPED)
    else $error("session end left mode running");

endmodule

`default_nettype wire
